[rtl/dba_pkg.sv]
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and constants of the direct beam attenuation core.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int unsigned TauW        = 24;
  localparam int unsigned CosW        = 16;
  localparam int unsigned FluxW       = 32;
  localparam int unsigned TauFracBits = 16;
  localparam int unsigned ArgFrac     = 16;
  localparam int unsigned ArgLimit    = 23;
  localparam int unsigned SeriesTerms = 11;
  localparam int unsigned DivW        = TauW + 31;
  localparam int unsigned DivorW      = 15;
  localparam int unsigned TW          = 33;
  localparam int unsigned SumW        = 35;
  localparam int unsigned ProdW       = 2 * TW;
  localparam int unsigned RecipW      = 37;
  localparam int unsigned RecipLoW    = 18;

  typedef enum logic [4:0] {
    SIdle, STopMul, STopWr, SEmitTop, SLayer, SDivRun, SSerInit, SSerMul,
    SSerDiv, SSerRun, SSerTake, SSerEnd, SPow, SPowWr, SFinMul, SFinWr, SEmitFin
  } dba_state_e;

  typedef enum logic [4:0] {
    OpNone, OpLoad, OpTopMul, OpTopWr, OpEmitTop, OpZeroFlux, OpDivStart,
    OpDivTake, OpTZero, OpSerInit, OpSerMul, OpSerDiv, OpSerHi, OpSerTake, OpSerEnd,
    OpPowMul, OpPowWr, OpFinMul, OpFinWr, OpEmitFin
  } dba_op_e;

  typedef struct packed {
    dba_op_e op;
  } dba_cmd_t;

  typedef struct packed {
    logic in_first;
    logic below;
    logic div_done;
    logic n_big;
    logic n_zero;
    logic k_last;
    logic phase_frac;
    logic out_free;
  } dba_status_t;

endpackage

[rtl/dba_if.sv]
// ----------------------------------------------------------------------------
// dba_in_if / dba_out_if
// Valid/ready channels carrying layer items and level results.
// ----------------------------------------------------------------------------
interface dba_in_if;
  logic               valid;
  logic               ready;
  logic [23:0]        optical_depth;
  logic signed [15:0] cos_zenith;
  logic [31:0]        incident_flux;
  logic               first_layer;
  modport source (output valid, optical_depth, cos_zenith, incident_flux, first_layer,
                  input ready);
  modport sink (input valid, optical_depth, cos_zenith, incident_flux, first_layer,
                output ready);
endinterface

interface dba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] level_flux;
  logic        last_of_run;
  modport source (output valid, level_flux, last_of_run, input ready);
  modport sink (input valid, level_flux, last_of_run, output ready);
endinterface

[rtl/direct_beam_attenuation_core.sv]
// ----------------------------------------------------------------------------
// direct_beam_attenuation_core
// Beer-Lambert attenuation of the direct solar beam through a layer stack.
// ----------------------------------------------------------------------------
// Usage: send one transaction per layer on in_i, top layer first, with
// first_layer set on the top layer of each column; that transaction also
// carries cos_zenith and incident_flux. A first-layer transaction yields two
// results on out_o (top level, then below the layer, last_of_run set); any
// other transaction yields one result with last_of_run set.
// Timing: one layer at a time; in_i is ready only while idle. With the sun up
// a layer is accepted and started, then tau/cos runs through the serial
// divider; n is the integer part of tau/cos (0 to 22). Two 11-term series
// for exp(-1) and exp(-frac) follow, one term at a time on the shared
// multiplier, then powering multiplies in exp(-1) n times and the final
// scaling closes the layer. An exponent of 23 or more skips the series. A
// sun at or below the horizon gives zero flux; a first layer adds the top level.
// Reset: column closed, sun below horizon, running flux zero; layers before
// the first column give zero flux.
// Stall: results sit in an output register; the core keeps computing and
// holds only when the next result is ready and the register is still full.
// ----------------------------------------------------------------------------
module direct_beam_attenuation_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  dba_in_if.sink   in_i,
  dba_out_if.source out_o
);
  import dba_pkg::*;

  dba_cmd_t    cmd;
  dba_status_t st;

  dba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .cmd_o     (cmd),
    .st_i      (st)
  );

  dba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_tau_i   (in_i.optical_depth),
    .in_cos_i   (in_i.cos_zenith),
    .in_inc_i   (in_i.incident_flux),
    .in_first_i (in_i.first_layer),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_flux_o (out_o.level_flux),
    .out_last_o (out_o.last_of_run)
  );
endmodule

[rtl/dba_div.sv]
// ----------------------------------------------------------------------------
// dba_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dba_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dba_pkg::DivW-1:0]   dividend_i,
  input  logic [dba_pkg::DivorW-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [dba_pkg::DivW-1:0]   quotient_o
);
  import dba_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]   quo_q;
  logic [DivorW-1:0] rem_q, dvs_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [DivorW:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivorW-1:0] : trial[DivorW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

[rtl/dba_ctrl.sv]
// ----------------------------------------------------------------------------
// dba_ctrl
// Sequencer: steps each layer through divide, series, powering and scaling.
// ----------------------------------------------------------------------------
module dba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output dba_pkg::dba_cmd_t    cmd_o,
  input  dba_pkg::dba_status_t st_i
);
  import dba_pkg::*;

  dba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OpNone;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OpLoad;
          state_d  = st_i.in_first ? STopMul : SLayer;
        end
      end
      STopMul: begin
        cmd_o.op = OpTopMul;
        state_d  = STopWr;
      end
      STopWr: begin
        cmd_o.op = OpTopWr;
        state_d  = SEmitTop;
      end
      SEmitTop: begin
        if (st_i.out_free) begin
          cmd_o.op = OpEmitTop;
          state_d  = SLayer;
        end
      end
      SLayer: begin
        if (st_i.below) begin
          cmd_o.op = OpZeroFlux;
          state_d  = SEmitFin;
        end else begin
          cmd_o.op = OpDivStart;
          state_d  = SDivRun;
        end
      end
      SDivRun: begin
        if (st_i.div_done) begin
          if (st_i.n_big) begin
            cmd_o.op = OpTZero;
            state_d  = SFinMul;
          end else begin
            cmd_o.op = OpDivTake;
            state_d  = SSerInit;
          end
        end
      end
      SSerInit: begin
        cmd_o.op = OpSerInit;
        state_d  = SSerMul;
      end
      SSerMul: begin
        cmd_o.op = OpSerMul;
        state_d  = SSerDiv;
      end
      SSerDiv: begin
        cmd_o.op = OpSerDiv;
        state_d  = SSerRun;
      end
      SSerRun: begin
        cmd_o.op = OpSerHi;
        state_d  = SSerTake;
      end
      SSerTake: begin
        cmd_o.op = OpSerTake;
        state_d  = st_i.k_last ? SSerEnd : SSerMul;
      end
      SSerEnd: begin
        cmd_o.op = OpSerEnd;
        state_d  = st_i.phase_frac ? SPow : SSerInit;
      end
      SPow: begin
        if (st_i.n_zero) begin
          state_d = SFinMul;
        end else begin
          cmd_o.op = OpPowMul;
          state_d  = SPowWr;
        end
      end
      SPowWr: begin
        cmd_o.op = OpPowWr;
        state_d  = SPow;
      end
      SFinMul: begin
        cmd_o.op = OpFinMul;
        state_d  = SFinWr;
      end
      SFinWr: begin
        cmd_o.op = OpFinWr;
        state_d  = SEmitFin;
      end
      SEmitFin: begin
        if (st_i.out_free) begin
          cmd_o.op = OpEmitFin;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

[rtl/dba_dp.sv]
// ----------------------------------------------------------------------------
// dba_dp
// Datapath: column state, shared multiplier, serial divider, output register.
// ----------------------------------------------------------------------------
module dba_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dba_pkg::dba_cmd_t           cmd_i,
  output dba_pkg::dba_status_t        st_o,
  input  logic [dba_pkg::TauW-1:0]    in_tau_i,
  input  logic signed [dba_pkg::CosW-1:0] in_cos_i,
  input  logic [dba_pkg::FluxW-1:0]   in_inc_i,
  input  logic                        in_first_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dba_pkg::FluxW-1:0]   out_flux_o,
  output logic                        out_last_o
);
  import dba_pkg::*;

  localparam logic [TW-1:0]   OneQ32 = TW'(1) << 32;
  localparam logic [DivW-1:0] NLimit = DivW'(ArgLimit) << (TauFracBits + ArgFrac);
  localparam logic [ArgFrac:0] GOne  = (ArgFrac + 1)'(1) << ArgFrac;

  // column state
  logic [FluxW-1:0] flux_q;
  logic [CosW-1:0]  cos_q;
  logic             below_q;
  logic             out_valid_q, out_last_q;
  logic [FluxW-1:0] out_flux_q;
  // work registers
  logic [TauW-1:0]    tau_q;
  logic [FluxW-1:0]   inc_q;
  logic [TW-1:0]      e1_q, t_q, term_q;
  logic [ArgFrac:0]   g_q;
  logic [ArgFrac-1:0] f_q;
  logic [4:0]         n_q;
  logic [3:0]         k_q;
  logic               phase_q;
  logic [SumW-1:0]    even_q, odd_q, sum_diff;
  logic [ProdW-1:0]   prod_q, prod_rnd;
  logic [TW-1:0]      mul_a, mul_b, ser_res;
  logic               out_free;
  // divide by term index: reciprocal multiply in two partial products
  logic [TW-1:0]      xk_q, lo_q, recip_quot;
  logic [RecipW-1:0]  recip;
  logic [ProdW-1:0]   recip_sum;
  // divider
  logic               div_start, div_busy, div_done;
  logic [DivW-1:0]    div_dividend, div_q;
  logic [DivorW-1:0]  div_divisor;

  dba_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  assign div_start    = (cmd_i.op == OpDivStart);
  assign div_dividend = {tau_q, 31'd0};
  assign div_divisor  = cos_q[DivorW-1:0];

  // ceil(2^36 / k), exact floor division for dividends up to 2^32
  always_comb begin
    unique case (k_q)
      4'd1:    recip = 37'd68719476736;
      4'd2:    recip = 37'd34359738368;
      4'd3:    recip = 37'd22906492246;
      4'd4:    recip = 37'd17179869184;
      4'd5:    recip = 37'd13743895348;
      4'd6:    recip = 37'd11453246123;
      4'd7:    recip = 37'd9817068106;
      4'd8:    recip = 37'd8589934592;
      4'd9:    recip = 37'd7635497416;
      4'd10:   recip = 37'd6871947674;
      4'd11:   recip = 37'd6247225158;
      default: recip = '0;
    endcase
  end

  assign recip_sum  = prod_q + ProdW'(lo_q);
  assign recip_quot = recip_sum[RecipLoW +: TW];

  always_comb begin
    unique case (cmd_i.op)
      OpTopMul: begin
        mul_a = TW'(inc_q);
        mul_b = TW'(cos_q[DivorW-1:0]);
      end
      OpSerMul: begin
        mul_a = term_q;
        mul_b = TW'(g_q);
      end
      OpSerDiv: begin
        mul_a = prod_q[ArgFrac +: TW];
        mul_b = TW'(recip[RecipLoW-1:0]);
      end
      OpSerHi: begin
        mul_a = xk_q;
        mul_b = TW'(recip[RecipW-1:RecipLoW]);
      end
      OpPowMul: begin
        mul_a = t_q;
        mul_b = e1_q;
      end
      default: begin
        mul_a = TW'(flux_q);
        mul_b = t_q;
      end
    endcase
  end

  assign prod_rnd = prod_q + (ProdW'(1) << 31);
  assign sum_diff = even_q - odd_q;
  always_comb begin
    if (odd_q > even_q) begin
      ser_res = '0;
    end else if (sum_diff > SumW'(OneQ32)) begin
      ser_res = OneQ32;
    end else begin
      ser_res = sum_diff[TW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_q      <= '0;
      cos_q       <= '0;
      below_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OpEmitTop || cmd_i.op == OpEmitFin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OpLoad: begin
          if (in_first_i) begin
            cos_q   <= in_cos_i;
            below_q <= (in_cos_i == '0) || in_cos_i[CosW-1];
          end
        end
        OpTopWr: begin
          flux_q <= below_q ? '0 : FluxW'((prod_q + (ProdW'(1) << 14)) >> 15);
        end
        OpZeroFlux: flux_q <= '0;
        OpFinWr:    flux_q <= prod_rnd[32 +: FluxW];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLoad: begin
        tau_q <= in_tau_i;
        inc_q <= in_inc_i;
      end
      OpTopMul, OpSerMul, OpPowMul, OpFinMul: prod_q <= mul_a * mul_b;
      OpSerDiv: begin
        prod_q <= mul_a * mul_b;
        xk_q   <= prod_q[ArgFrac +: TW];
      end
      OpSerHi: begin
        prod_q <= mul_a * mul_b;
        lo_q   <= prod_q[RecipLoW +: TW];
      end
      OpEmitTop: begin
        out_flux_q <= flux_q;
        out_last_q <= 1'b0;
      end
      OpEmitFin: begin
        out_flux_q <= flux_q;
        out_last_q <= 1'b1;
      end
      OpTZero: t_q <= '0;
      OpDivTake: begin
        f_q     <= div_q[TauFracBits +: ArgFrac];
        n_q     <= div_q[TauFracBits + ArgFrac +: 5];
        g_q     <= GOne;
        phase_q <= 1'b0;
      end
      OpSerInit: begin
        term_q <= OneQ32;
        even_q <= SumW'(OneQ32);
        odd_q  <= '0;
        k_q    <= 4'd1;
      end
      OpSerTake: begin
        term_q <= recip_quot;
        if (k_q[0]) begin
          odd_q <= odd_q + SumW'(recip_quot);
        end else begin
          even_q <= even_q + SumW'(recip_quot);
        end
        k_q <= k_q + 1'b1;
      end
      OpSerEnd: begin
        if (!phase_q) begin
          e1_q    <= ser_res;
          g_q     <= {1'b0, f_q};
          phase_q <= 1'b1;
        end else begin
          t_q <= ser_res;
        end
      end
      OpPowWr: begin
        t_q <= prod_rnd[32 +: TW];
        n_q <= n_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign st_o.in_first   = in_first_i;
  assign st_o.below      = below_q;
  assign st_o.div_done   = div_done;
  assign st_o.n_big      = div_q >= NLimit;
  assign st_o.n_zero     = (n_q == '0);
  assign st_o.k_last     = (k_q == 4'(SeriesTerms));
  assign st_o.phase_frac = phase_q;
  assign st_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_flux_o  = out_flux_q;
  assign out_last_o  = out_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpEmitTop || cmd_i.op == OpEmitFin) |-> out_free)
    else $error("result written over a pending result");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_take_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpDivTake) |-> div_done)
    else $error("quotient taken before divider finished");
  a_below_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpEmitFin && below_q) |-> flux_q == '0)
    else $error("nonzero flux emitted with sun below horizon");
endmodule

[dv/direct_beam_attenuation_core_test.sv]
// ----------------------------------------------------------------------------
// direct_beam_attenuation_core_test
// Drives layer transactions into the attenuation core and compares every
// level flux against an in-bench Beer-Lambert predictor in fixed point.
// Directed corner columns come first, then random columns with random
// source gaps, sink stalls, a long sink hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_beam_attenuation_core_test;
  import dba_pkg::*;

  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned LongHold   = 4000;

  typedef struct {
    logic [23:0]        tau;
    logic signed [15:0] cosz;
    logic [31:0]        flux_in;
    logic               first;
    int unsigned        gap;
    bit                 drain;
  } layer_t;

  typedef struct {
    logic [31:0] flux;
    logic        last;
  } level_t;

  logic clk_i;
  logic rst_ni;

  dba_in_if  in_if ();
  dba_out_if out_if ();

  direct_beam_attenuation_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  layer_t      layer_q[$];
  level_t      level_q[$];
  layer_t      cur;
  bit          loaded;
  bit          in_taken;
  bit          out_taken;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned results_seen;
  int unsigned cycles;
  int unsigned errors;
  bit          src_idle_on;
  bit          snk_idle_on;
  bit          long_done;

  // predictor state
  logic [31:0] col_flux;
  logic [15:0] col_cos;
  bit          col_dark;

  function automatic logic [63:0] exp_neg(logic [63:0] g);
    logic [63:0] term;
    logic [63:0] even;
    logic [63:0] odd;
    logic [63:0] res;
    term = 64'd1 << 32;
    even = 64'd1 << 32;
    odd  = '0;
    for (int unsigned k = 1; k <= SeriesTerms; k++) begin
      term = ((term * g) >> ArgFrac) / k;
      if (k % 2) odd += term;
      else even += term;
    end
    res = (odd > even) ? 64'd0 : even - odd;
    return (res > (64'd1 << 32)) ? (64'd1 << 32) : res;
  endfunction

  function automatic logic [63:0] transmit(logic [23:0] tau, logic [15:0] cosv);
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] t;
    logic [63:0] e1;
    q = ({40'd0, tau} << 31) / {48'd0, cosv};
    x = q >> TauFracBits;
    n = x >> ArgFrac;
    if (n >= ArgLimit) return 64'd0;
    t  = exp_neg(x & 64'hFFFF);
    e1 = exp_neg(64'd1 << ArgFrac);
    for (int unsigned i = 0; i < n; i++) t = (t * e1 + (64'd1 << 31)) >> 32;
    return t;
  endfunction

  task automatic predict_levels(layer_t it);
    logic [63:0] p;
    if (it.first) begin
      col_cos  = it.cosz;
      col_dark = (it.cosz <= 0);
      if (col_dark) col_flux = '0;
      else begin
        p = {32'd0, it.flux_in} * {48'd0, col_cos} + (64'd1 << 14);
        col_flux = p[46:15];
      end
      level_q.push_back('{flux: col_flux, last: 1'b0});
    end
    if (col_dark) col_flux = '0;
    else begin
      p = {32'd0, col_flux} * transmit(it.tau, col_cos) + (64'd1 << 31);
      col_flux = p[63:32];
    end
    level_q.push_back('{flux: col_flux, last: 1'b1});
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // monitor: sample at the rising edge
  always @(posedge clk_i) begin
    level_t exp_lv;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
      if (in_if.valid && in_if.ready) begin
        in_taken = 1'b1;
        predict_levels('{tau: in_if.optical_depth, cosz: in_if.cos_zenith,
                         flux_in: in_if.incident_flux, first: in_if.first_layer,
                         gap: 0, drain: 0});
      end
      if (out_if.valid && out_if.ready) begin
        out_taken = 1'b1;
        results_seen++;
        if (level_q.size() == 0) begin
          $error("unexpected result: level_flux %h", out_if.level_flux);
          errors++;
        end else begin
          exp_lv = level_q.pop_front();
          if (out_if.level_flux !== exp_lv.flux) begin
            $error("level_flux expected %h actual %h", exp_lv.flux, out_if.level_flux);
            errors++;
          end
          if (out_if.last_of_run !== exp_lv.last) begin
            $error("last_of_run expected %b actual %b", exp_lv.last, out_if.last_of_run);
            errors++;
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    bit present;
    present = 1'b0;
    if (rst_ni) begin
      if (in_taken) begin
        loaded   = 1'b0;
        in_taken = 1'b0;
      end
      if (!loaded && layer_q.size() > 0) begin
        cur      = layer_q.pop_front();
        gap_left = cur.gap;
        loaded   = 1'b1;
      end
      if (loaded) begin
        if (cur.drain && level_q.size() > 0) present = 1'b0;
        else if (gap_left > 0) gap_left--;
        else present = 1'b1;
      end
    end
    in_if.valid         <= present;
    in_if.optical_depth <= cur.tau;
    in_if.cos_zenith    <= cur.cosz;
    in_if.incident_flux <= cur.flux_in;
    in_if.first_layer   <= cur.first;
  end

  // sink stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) snk_idle_on = ~snk_idle_on;
        hold_left = snk_idle_on ? $urandom_range(0, 12) : 0;
        if (!long_done && results_seen >= 300) begin
          hold_left = LongHold;
          long_done = 1'b1;
        end
      end
      if (hold_left > 0) hold_left--;
    end
    out_if.ready <= rst_ni && (hold_left == 0);
  end

  task automatic add_layer(logic [23:0] tau, logic signed [15:0] cosz, logic [31:0] flux_in,
                           logic first, bit drain);
    if ($urandom_range(0, 39) == 0) src_idle_on = ~src_idle_on;
    layer_q.push_back('{tau: tau, cosz: cosz, flux_in: flux_in, first: first,
                        gap: src_idle_on ? $urandom_range(0, 12) : 0, drain: drain});
  endtask

  initial begin
    int unsigned n_items;
    int unsigned layers;
    logic signed [15:0] c;
    logic [23:0] tau;
    int unsigned sel;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.optical_depth = '0;
    in_if.cos_zenith = '0;
    in_if.incident_flux = '0;
    in_if.first_layer = 1'b0;
    out_if.ready = 1'b0;
    cur = '{tau: 0, cosz: 0, flux_in: 0, first: 0, gap: 0, drain: 0};
    loaded = 0; in_taken = 0; out_taken = 0; gap_left = 0; hold_left = 0;
    results_seen = 0; cycles = 0; errors = 0; src_idle_on = 1; snk_idle_on = 1;
    long_done = 0;
    col_flux = '0; col_cos = '0; col_dark = 1'b1;

    // layers before any column, then corner columns
    add_layer(24'd0, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'hFFFFFF, 16'sd32767, 32'hFFFFFFFF, 1'b0, 0);
    add_layer(24'd0, 16'sd32767, 32'hFFFFFFFF, 1'b1, 0);
    add_layer(24'd1, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'd65536, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'hFFFFFF, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'd0, 16'sd1, 32'h12345678, 1'b1, 0);
    add_layer(24'd1, 16'sd1, 32'd0, 1'b0, 0);
    add_layer(24'd753663, 16'sd16384, 32'hFFFFFFFF, 1'b1, 1);
    add_layer(24'd753664, 16'sd16384, 32'hFFFFFFFF, 1'b1, 0);
    add_layer(24'd300, 16'sd0, 32'hFFFFFFFF, 1'b1, 0);
    add_layer(24'd300, 16'sd0, 32'hFFFFFFFF, 1'b0, 0);
    add_layer(24'd300, -16'sd32768, 32'hFFFFFFFF, 1'b1, 0);
    add_layer(24'd300, -16'sd1, 32'hAAAAAAAA, 1'b1, 0);
    add_layer(24'd300, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'd4096, 16'sd23170, 32'd0, 1'b1, 0);
    add_layer(24'd4096, 16'sd23170, 32'h55555555, 1'b1, 0);
    add_layer(24'd65536, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'd32768, 16'sd0, 32'd0, 1'b0, 0);
    add_layer(24'hFFFFFF, 16'sd0, 32'd0, 1'b0, 0);
    n_items = 20;

    while (n_items < 1900) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) c = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 255))
                                                    : 16'($urandom_range(1, 32767));
      else c = -$signed({1'b0, 15'($urandom_range(0, 32767))});
      layers = $urandom_range(1, 10);
      for (int unsigned l = 0; l < layers; l++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) tau = 24'($urandom_range(0, 255));
        else if (sel < 85) tau = 24'($urandom_range(0, 4 * c));
        else if (sel < 93) tau = 24'($urandom_range(0, 46 * c + 100));
        else tau = 24'($urandom_range(0, 24'hFFFFFF));
        add_layer(tau, l == 0 ? c : 16'($urandom),
                  l == 0 ? $urandom : $urandom,
                  l == 0, n_items >= 1000 && n_items < 1010 && l == 0);
        n_items++;
      end
      if ($urandom_range(0, 49) == 0) begin
        add_layer(24'($urandom_range(0, 24'hFFFFFF)), 16'($urandom), $urandom, 1'b1, 0);
        n_items++;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (layer_q.size() > 0 || loaded || level_q.size() > 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (errors == 0 && level_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[direct_beam_attenuation_core.f]
rtl/dba_pkg.sv
rtl/dba_if.sv
rtl/dba_div.sv
rtl/dba_ctrl.sv
rtl/dba_dp.sv
rtl/direct_beam_attenuation_core.sv
dv/direct_beam_attenuation_core_test.sv
